FILE: design/wvm_pkg.sv
// Package for the wavetable voice mixer: widths, table geometry, register
// and request codes, and the struct that carries table requests.
// Self-contained; used by every module of the block.
package wvm_pkg;

    localparam int TABLE_DEPTH = 32;  // must be a power of two
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);

    localparam int PHASE_W    = 32;
    localparam int VOL_W      = 4;
    localparam int SAMPLE_W   = 8;
    localparam int IDX_W      = 5;
    localparam int CFG_DATA_W = 32;
    localparam int PHASE_LSB  = 16;
    localparam int PROD_W     = SAMPLE_W + VOL_W;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'h0010_0000;
    localparam logic [VOL_W-1:0]   VOLUME_RST     = 4'd12;

    typedef enum logic [0:0] {
        CFG_PHASE_STEP = 1'b0,
        CFG_VOLUME     = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        REQ_TICK  = 1'b0,
        REQ_WRITE = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic                wr_en;
        logic [TBL_AW-1:0]   wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
        logic                rd_en;
        logic [TBL_AW-1:0]   rd_addr;
    } tbl_req_t;

endpackage

FILE: design/wavetable_voice_mixer_unit.sv
// Top level of the wavetable voice mixer: configuration registers, phase
// accumulator, request handshake and the table and output stages.
// Depends on wvm_pkg, wvm_table and wvm_scale.
//
// One voice of a 32-entry wavetable oscillator. The block takes one request
// per clock cycle while req_stall is low: a write request stores a byte in
// the table and returns nothing, a tick request advances the 32-bit phase
// and returns one sample through the table's registered read port and then
// the output register. The table reads as all zero after reset without any
// clearing pass. Requests are stalled only while a tick waits in the read
// stage and the output register holds a result that is not taken. The user
// is to write configuration through cfg_we only while the block is idle; the
// block does not enforce this. phase_step is index 0 and volume is index 1.
module wavetable_voice_mixer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [0:0]                          cfg_index,
    input  logic [wvm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [0:0]                          req_type,
    input  logic [wvm_pkg::IDX_W-1:0]           table_index,
    input  logic [wvm_pkg::SAMPLE_W-1:0]        table_value,
    output logic                                sample_valid,
    input  logic                                sample_stall,
    output logic [wvm_pkg::SAMPLE_W-1:0]        sample_out
);

    logic [wvm_pkg::PHASE_W-1:0]  phase_step_reg;
    logic [wvm_pkg::VOL_W-1:0]    volume_reg;
    logic [wvm_pkg::PHASE_W-1:0]  phase_acc_reg;
    logic [wvm_pkg::PHASE_W-1:0]  phase_acc_next;
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic                         out_load;
    logic                         req_accept;
    logic                         tick_accept;
    logic                         write_accept;
    logic                         index_in_range;
    logic [wvm_pkg::SAMPLE_W-1:0] rd_data;
    wvm_pkg::tbl_req_t            tbl_req;

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= wvm_pkg::PHASE_STEP_RST;
            volume_reg     <= wvm_pkg::VOLUME_RST;
        end
        else if (cfg_we)
        begin
            unique case (wvm_pkg::cfg_reg_t'(cfg_index))
                wvm_pkg::CFG_PHASE_STEP: phase_step_reg <= cfg_data;
                wvm_pkg::CFG_VOLUME:     volume_reg <= cfg_data[wvm_pkg::VOL_W-1:0];
                default:                 ;
            endcase
        end
    end

    // The output register can load when it is empty or its result is taken.
    assign out_load     = ~sample_valid | ~sample_stall;
    assign req_stall    = s1_valid_reg & ~out_load;
    assign req_accept   = req_valid & ~req_stall;
    assign tick_accept  = req_accept & (req_type == wvm_pkg::REQ_TICK);
    assign write_accept = req_accept & (req_type == wvm_pkg::REQ_WRITE);

    assign index_in_range = 32'(table_index) < wvm_pkg::TABLE_DEPTH;
    assign phase_acc_next = phase_acc_reg + phase_step_reg;
    assign s1_valid_next  = tick_accept | (s1_valid_reg & ~out_load);

    always_comb
    begin
        tbl_req.wr_en   = write_accept & index_in_range;
        tbl_req.wr_addr = wvm_pkg::TBL_AW'(table_index);
        tbl_req.wr_data = table_value;
        tbl_req.rd_en   = tick_accept;
        tbl_req.rd_addr = phase_acc_next[wvm_pkg::PHASE_LSB +: wvm_pkg::TBL_AW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (tick_accept)
            begin
                phase_acc_reg <= phase_acc_next;
            end
            s1_valid_reg <= s1_valid_next;
        end
    end

    wvm_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .rd_data (rd_data)
    );

    wvm_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (s1_valid_reg & out_load),
        .sample_byte (rd_data),
        .volume      (volume_reg),
        .out_stall   (sample_stall),
        .out_valid   (sample_valid),
        .out_sample  (sample_out)
    );

    // An accepted tick always reaches the read stage.
    a_tick_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept |=> s1_valid_reg)
        else $error("accepted tick did not enter the read stage");

    // A tick held in the read stage is not dropped while the output is blocked.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_load) |=> s1_valid_reg)
        else $error("tick lost from the read stage");

    // The phase moves exactly by the step on every tick.
    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept |=> (phase_acc_reg == $past(phase_acc_next)))
        else $error("phase accumulator did not advance by the step");

    // A result leaves the read stage only into an output register that can take it.
    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_load) |=> sample_valid)
        else $error("result from the read stage was not registered");

endmodule

FILE: design/wvm_table.sv
// Wave table storage: a synchronous memory with a registered read port and
// one valid bit per entry so that unwritten entries read as zero.
// Depends on wvm_pkg.
module wvm_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  wvm_pkg::tbl_req_t                req,
    output logic [wvm_pkg::SAMPLE_W-1:0]     rd_data
);

    logic [wvm_pkg::SAMPLE_W-1:0]    mem [wvm_pkg::TABLE_DEPTH];
    logic [wvm_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic [wvm_pkg::SAMPLE_W-1:0]    rd_data_reg;
    logic                            rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_hit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // An entry never written since reset reads as zero through its cleared valid bit.
    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

FILE: design/wvm_scale.sv
// Output stage: scales the signed table byte by the volume, saturates,
// offsets to unsigned and holds the result in the output register.
// Depends on wvm_pkg.
module wvm_scale (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             take,
    input  logic [wvm_pkg::SAMPLE_W-1:0]     sample_byte,
    input  logic [wvm_pkg::VOL_W-1:0]        volume,
    input  logic                             out_stall,
    output logic                             out_valid,
    output logic [wvm_pkg::SAMPLE_W-1:0]     out_sample
);

    logic                           neg;
    logic [wvm_pkg::SAMPLE_W-1:0]   mag;
    logic [wvm_pkg::PROD_W-1:0]     prod;
    logic [wvm_pkg::SAMPLE_W:0]     scaled;
    logic [wvm_pkg::SAMPLE_W-1:0]   sample_next;
    logic [wvm_pkg::SAMPLE_W-1:0]   sample_reg;
    logic                           valid_next;
    logic                           valid_reg;

    always_comb
    begin
        neg = sample_byte[wvm_pkg::SAMPLE_W-1];
        // The byte 0x80 negates to itself, which is the magnitude 128.
        mag = neg ? ((~sample_byte) + 8'd1) : sample_byte;
        prod = wvm_pkg::PROD_W'(mag) * wvm_pkg::PROD_W'(volume);
        scaled = {1'b0, prod[wvm_pkg::PROD_W-1:wvm_pkg::VOL_W]};
        if (neg)
        begin
            sample_next = (scaled > 9'd128) ? 8'd0 : 8'(9'd128 - scaled);
        end
        else
        begin
            sample_next = (scaled > 9'd127) ? 8'd255 : 8'(9'd128 + scaled);
        end
    end

    assign valid_next = take | (valid_reg & out_stall);

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sample_reg <= sample_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_sample = sample_reg;

endmodule

FILE: tb/wavetable_voice_mixer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the wavetable voice mixer top level.
// Depends on wvm_pkg and wavetable_voice_mixer_unit; holds its own voice model.
module wavetable_voice_mixer_unit_tb;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [0:0]                     cfg_index;
    logic [wvm_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           req_valid;
    logic                           req_stall;
    logic [0:0]                     req_type;
    logic [wvm_pkg::IDX_W-1:0]      table_index;
    logic [wvm_pkg::SAMPLE_W-1:0]   table_value;
    logic                           sample_valid;
    logic                           sample_stall;
    logic [wvm_pkg::SAMPLE_W-1:0]   sample_out;

    // Model of the voice: configuration, phase and a copy of the table.
    logic [wvm_pkg::PHASE_W-1:0]    step_image;
    logic [wvm_pkg::VOL_W-1:0]      volume_image;
    logic [wvm_pkg::PHASE_W-1:0]    phase_image;
    logic [wvm_pkg::SAMPLE_W-1:0]   table_image [wvm_pkg::TABLE_DEPTH];
    logic [wvm_pkg::SAMPLE_W-1:0]   expected_samples [$];

    int error_count = 0;
    int tick_count = 0;
    int write_count = 0;
    int sample_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_cycles = 0;

    wavetable_voice_mixer_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_type     (req_type),
        .table_index  (table_index),
        .table_value  (table_value),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_out   (sample_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Timeout: expected samples still pending: %0d", expected_samples.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Scales a two's complement table byte by the volume and converts it
    // to offset binary.
    function automatic logic [wvm_pkg::SAMPLE_W-1:0] scaled_output(
        input logic [wvm_pkg::SAMPLE_W-1:0] b,
        input logic [wvm_pkg::VOL_W-1:0]    vol);
        logic [8:0]  mag;
        logic [12:0] prod;
        int          mix;
        if (b[wvm_pkg::SAMPLE_W-1])
            mag = 9'd256 - {1'b0, b};
        else
            mag = {1'b0, b};
        prod = mag * vol;
        mix = int'(prod >> 4);
        if (b[wvm_pkg::SAMPLE_W-1])
            mix = -mix;
        if (mix > 127)
            mix = 127;
        if (mix < -128)
            mix = -128;
        return wvm_pkg::SAMPLE_W'(mix + 128);
    endfunction

    task automatic advance_voice(input wvm_pkg::req_kind_t kind,
                                 input logic [wvm_pkg::IDX_W-1:0] idx,
                                 input logic [wvm_pkg::SAMPLE_W-1:0] val);
        logic [wvm_pkg::TBL_AW-1:0] offs;
        if (kind == wvm_pkg::REQ_WRITE)
        begin
            table_image[idx] = val;
            write_count++;
        end
        else
        begin
            phase_image = phase_image + step_image;
            offs = phase_image[wvm_pkg::PHASE_LSB +: wvm_pkg::TBL_AW];
            expected_samples.push_back(scaled_output(table_image[offs], volume_image));
            tick_count++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("Mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Offers one request, idling first at the current rate, and updates the
    // model at the edge where the request is taken.
    task automatic send_request(input wvm_pkg::req_kind_t kind,
                                input logic [wvm_pkg::IDX_W-1:0] idx,
                                input logic [wvm_pkg::SAMPLE_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            req_valid   <= 1'b0;
            req_type    <= 1'($urandom_range(1));
            table_index <= wvm_pkg::IDX_W'($urandom_range(31));
            table_value <= wvm_pkg::SAMPLE_W'($urandom_range(255));
        end
        @(negedge clk);
        req_valid   <= 1'b1;
        req_type    <= kind;
        table_index <= idx;
        table_value <= val;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        advance_voice(kind, idx, val);
    endtask

    task automatic send_random_request(input int write_pct);
        wvm_pkg::req_kind_t kind;
        kind = ($urandom_range(99) < write_pct) ? wvm_pkg::REQ_WRITE : wvm_pkg::REQ_TICK;
        send_request(kind, wvm_pkg::IDX_W'($urandom_range(31)),
                     wvm_pkg::SAMPLE_W'($urandom_range(255)));
    endtask

    // Drops the request line and waits until every sample has come out, then
    // waits on for a write still in flight.
    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input wvm_pkg::cfg_reg_t r,
                                  input logic [wvm_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (r == wvm_pkg::CFG_PHASE_STEP)
            step_image = data;
        else
            volume_image = data[wvm_pkg::VOL_W-1:0];
    endtask

    task automatic reconfigure(input logic [wvm_pkg::PHASE_W-1:0] step,
                               input logic [wvm_pkg::VOL_W-1:0] vol);
        wait_idle();
        write_register(wvm_pkg::CFG_PHASE_STEP, step);
        write_register(wvm_pkg::CFG_VOLUME, wvm_pkg::CFG_DATA_W'(vol));
    endtask

    // Two ticks at the reset configuration read the cleared table and leave
    // the phase at table entry zero.
    task automatic test_reset_state();
        repeat (2)
            send_request(wvm_pkg::REQ_TICK, wvm_pkg::IDX_W'($urandom_range(31)),
                         wvm_pkg::SAMPLE_W'($urandom_range(255)));
    endtask

    // Sign, magnitude and most negative byte cases at full and zero volume.
    task automatic test_sample_extremes();
        logic [wvm_pkg::SAMPLE_W-1:0] extremes [8];
        extremes = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h01, 8'h81, 8'h40, 8'hC0};
        for (int i = 0; i < 8; i++)
            send_request(wvm_pkg::REQ_WRITE, wvm_pkg::IDX_W'(i + 1), extremes[i]);
        reconfigure(32'h0001_0000, 4'd15);
        repeat (8)
            send_request(wvm_pkg::REQ_TICK, '0, '0);
        reconfigure(32'h0001_0000, 4'd0);
        repeat (2)
            send_request(wvm_pkg::REQ_TICK, '1, '1);
    endtask

    task automatic test_random_phases();
        logic [wvm_pkg::PHASE_W-1:0] step;
        logic [wvm_pkg::VOL_W-1:0]   vol;
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0:
                begin
                    step = 32'hFFFF_FFFF;
                    vol  = 4'd15;
                end
                1:
                begin
                    step = 32'h0000_0000;
                    vol  = 4'd0;
                end
                2:
                begin
                    step = $urandom;
                    vol  = wvm_pkg::VOL_W'($urandom_range(15));
                end
                3:
                begin
                    step = 32'h0001_0000;
                    vol  = wvm_pkg::VOL_W'($urandom_range(15));
                end
                4:
                begin
                    step = $urandom_range(32'h0008_0000);
                    vol  = 4'd15;
                end
                5:
                begin
                    step = $urandom;
                    vol  = 4'd1;
                end
                default:
                begin
                    step = $urandom;
                    vol  = wvm_pkg::VOL_W'($urandom_range(15));
                end
            endcase
            reconfigure(step, vol);
            if (p < 3)
            begin
                send_idle_pct = 22;
                recv_idle_pct = 83;
            end
            else if (p < 5)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (140)
                send_random_request(30);
        end
    endtask

    // The receiver stops for a long stretch while ticks keep coming, so the
    // block fills and stalls its input; then the sender waits for the drain.
    task automatic test_backpressure();
        reconfigure($urandom, wvm_pkg::VOL_W'($urandom_range(15)));
        send_idle_pct   = 0;
        recv_idle_pct   = 30;
        hold_off_cycles = 300;
        repeat (60)
            send_random_request(10);
        wait_idle();
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial
    begin
        sample_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                sample_stall <= 1'b1;
                hold_off_cycles--;
            end
            else
                sample_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sample_valid && !sample_stall)
        begin
            sample_count++;
            if (expected_samples.size() == 0)
                report_mismatch("unexpected sample_out", 32'(sample_out), 32'h0);
            else if (sample_out !== expected_samples[0])
                report_mismatch("sample_out", 32'(sample_out), 32'(expected_samples[0]));
            if (expected_samples.size() != 0)
                void'(expected_samples.pop_front());
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = wvm_pkg::CFG_PHASE_STEP;
        cfg_data    = '0;
        req_valid   = 1'b0;
        req_type    = wvm_pkg::REQ_TICK;
        table_index = '0;
        table_value = '0;
        step_image   = wvm_pkg::PHASE_STEP_RST;
        volume_image = wvm_pkg::VOLUME_RST;
        phase_image  = '0;
        foreach (table_image[i])
            table_image[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_sample_extremes();
        test_random_phases();
        test_backpressure();

        wait_idle();
        repeat (10) @(posedge clk);
        while (expected_samples.size() != 0)
        begin
            report_mismatch("missing sample", 32'h0, 32'(expected_samples[0]));
            void'(expected_samples.pop_front());
        end
        $display("Covered %0d ticks and %0d table writes, %0d samples checked,",
                 tick_count, write_count, sample_count);
        $display("over phase step and volume extremes, random stalls and a long hold-off.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: wavetable_voice_mixer_unit.f
design/wvm_pkg.sv
design/wvm_table.sv
design/wvm_scale.sv
design/wavetable_voice_mixer_unit.sv
tb/wavetable_voice_mixer_unit_tb.sv
